FILE: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/rmbp_pkg.sv
// Package: types, codes and constants of the multibulk request parser.
package rmbp_pkg;

    localparam int COUNT_BITS_DEF  = 21;
    localparam int LENGTH_BITS_DEF = 30;

    localparam int MAX_ARG_W   = 21;
    localparam int MAX_BULK_W  = 30;
    localparam int CFG_DATA_W  = 30;
    localparam int CFG_INDEX_W = 1;
    localparam int ACC_W       = 31;
    localparam int ARG_INDEX_W = 20;

    localparam logic [MAX_ARG_W-1:0]  MAX_ARG_RESET  = MAX_ARG_W'(1024 * 1024);
    localparam logic [MAX_BULK_W-1:0] MAX_BULK_RESET = MAX_BULK_W'(512 * 1024 * 1024);

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ARG_COUNT   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_BULK_LENGTH = 1'd1;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;

    localparam logic [ACC_W+3:0] ACC_CAP = 35'h0_7FFF_FFFF;

    // event codes
    localparam logic [1:0] EV_PAYLOAD = 2'd0;
    localparam logic [1:0] EV_ARG_END = 2'd1;
    localparam logic [1:0] EV_CMD_END = 2'd2;
    localparam logic [1:0] EV_ERROR   = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_COUNT  = 2'd1;
    localparam logic [1:0] ERR_NO_DOLLAR  = 2'd2;
    localparam logic [1:0] ERR_BAD_LENGTH = 2'd3;

    // progress within a number: nothing seen, sign seen, digits seen
    localparam logic [1:0] SUB_NONE   = 2'd0;
    localparam logic [1:0] SUB_SIGN   = 2'd1;
    localparam logic [1:0] SUB_DIGITS = 2'd2;

    typedef struct packed {
        logic       clr;
        logic       feed;
        logic [1:0] sub;
        logic [7:0] rx_char;
    } num_ctl_t;

    typedef struct packed {
        logic [ACC_W-1:0] accum;
        logic             negative;
        logic             invalid;
        logic [1:0]       sub_next;
    } num_st_t;

endpackage

FILE: rtl/core/resp_multibulk_request_parser.sv
// Top level of the multibulk request parser.
//
// Input channel rx: one request byte per transaction (rx_valid, rx_stall, rx_byte).
// Output channel ev: one event per transaction (ev_valid, ev_stall, event_res,
// data, arg_index, error_code). Bytes of headers, counts, lengths, line ends
// and the first trailer byte produce no event.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 max argument
// count, 1 max bulk length) at the clock edge; write only while idle.
// The byte is registered at the accepting edge, then processed and its event
// registered in the result register. Throughput: one byte per cycle unless the
// result register is full and stalled; the phase/counter update of one byte is
// done before the next byte, so bytes stream back to back.
// Stall: ev_stall holds the result register; rx_stall rises only while the
// input register holds a byte and the result register is full and stalled.
// Reset (rst_n low, asynchronous): parser returns to waiting for a header
// byte, limits return to their defaults, both registers empty. After a
// protocol error the parser drops every byte until reset.
module resp_multibulk_request_parser #(
    parameter int COUNT_BITS  = rmbp_pkg::COUNT_BITS_DEF,
    parameter int LENGTH_BITS = rmbp_pkg::LENGTH_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rmbp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rmbp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 rx_valid,
    output logic                                 rx_stall,
    input  logic [7:0]                           rx_byte,
    output logic                                 ev_valid,
    input  logic                                 ev_stall,
    output logic [1:0]                           event_res,
    output logic [7:0]                           data,
    output logic [rmbp_pkg::ARG_INDEX_W-1:0]     arg_index,
    output logic [1:0]                           error_code
);
    import rmbp_pkg::*;

    logic [MAX_ARG_W-1:0]  max_arg_reg;
    logic [MAX_BULK_W-1:0] max_bulk_reg;
    logic [7:0]            byte_reg;
    logic                  byte_vld_reg, byte_vld_next;
    logic                  advance;
    logic                  rx_take;
    num_ctl_t              num_ctl;
    num_st_t               num_st;

    // the held byte moves on unless the result register is full and stalled
    assign advance  = byte_vld_reg && !(ev_valid && ev_stall);
    assign rx_stall = byte_vld_reg && !advance;
    assign rx_take  = rx_valid && !rx_stall;
    assign byte_vld_next = rx_take || (byte_vld_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_arg_reg  <= MAX_ARG_RESET;
            max_bulk_reg <= MAX_BULK_RESET;
            byte_vld_reg <= 1'b0;
        end
        else
        begin
            byte_vld_reg <= byte_vld_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_ARG_COUNT:   max_arg_reg  <= cfg_data[MAX_ARG_W-1:0];
                    REG_MAX_BULK_LENGTH: max_bulk_reg <= cfg_data[MAX_BULK_W-1:0];
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
            byte_reg <= rx_byte;
    end

    rmbp_num u_num (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (num_ctl),
        .st    (num_st)
    );

    rmbp_fsm #(
        .COUNT_BITS  (COUNT_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_fsm (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .rx_char         (byte_reg),
        .max_arg_count   (max_arg_reg),
        .max_bulk_length (max_bulk_reg),
        .num_st          (num_st),
        .num_ctl         (num_ctl),
        .ev_stall        (ev_stall),
        .ev_valid        (ev_valid),
        .event_res       (event_res),
        .data            (data),
        .arg_index       (arg_index),
        .error_code      (error_code)
    );

endmodule

FILE: rtl/core/rmbp_num.sv
// Decimal number accumulator: sign, digits, syntax check and saturation.
module rmbp_num (
    input  logic             clk,
    input  logic             rst_n,
    input  rmbp_pkg::num_ctl_t ctl,
    output rmbp_pkg::num_st_t  st
);
    import rmbp_pkg::*;

    logic [ACC_W-1:0] accum_reg, accum_next;
    logic             negative_reg, negative_next;
    logic             invalid_reg, invalid_next;
    logic [1:0]       sub_next;
    logic             is_digit;
    logic [3:0]       digit;
    logic [ACC_W+3:0] acc_x10;

    assign is_digit = (ctl.rx_char >= CH_DIGIT_0) && (ctl.rx_char <= CH_DIGIT_9);
    assign digit    = ctl.rx_char[3:0];
    assign acc_x10  = ((ACC_W+4)'(accum_reg) << 3) + ((ACC_W+4)'(accum_reg) << 1)
                    + (ACC_W+4)'(digit);

    always_comb
    begin
        accum_next    = accum_reg;
        negative_next = negative_reg;
        invalid_next  = invalid_reg;
        sub_next      = ctl.sub;
        if (ctl.clr)
        begin
            accum_next    = '0;
            negative_next = 1'b0;
            invalid_next  = 1'b0;
        end
        else if (ctl.feed)
        begin
            if ((ctl.rx_char == CH_MINUS) && (ctl.sub == SUB_NONE))
            begin
                negative_next = 1'b1;
                sub_next      = SUB_SIGN;
            end
            else if (!is_digit)
            begin
                invalid_next = 1'b1;
            end
            else if (ctl.sub == SUB_DIGITS)
            begin
                // leading zero followed by more digits
                if (accum_reg == '0)
                begin
                    invalid_next = 1'b1;
                end
                else if (acc_x10 > ACC_CAP)
                begin
                    accum_next   = ACC_CAP[ACC_W-1:0];
                    invalid_next = 1'b1;
                end
                else
                begin
                    accum_next = acc_x10[ACC_W-1:0];
                end
            end
            else
            begin
                // "-0" is rejected
                if ((ctl.sub == SUB_SIGN) && (digit == 4'd0))
                    invalid_next = 1'b1;
                accum_next = ACC_W'(digit);
                sub_next   = SUB_DIGITS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg    <= '0;
            negative_reg <= 1'b0;
            invalid_reg  <= 1'b0;
        end
        else
        begin
            accum_reg    <= accum_next;
            negative_reg <= negative_next;
            invalid_reg  <= invalid_next;
        end
    end

    assign st.accum    = accum_reg;
    assign st.negative = negative_reg;
    assign st.invalid  = invalid_reg;
    assign st.sub_next = sub_next;

endmodule

FILE: rtl/core/rmbp_fsm.sv
// Parser sequencer: phase, argument and payload counters, result register.
module rmbp_fsm #(
    parameter int COUNT_BITS  = rmbp_pkg::COUNT_BITS_DEF,
    parameter int LENGTH_BITS = rmbp_pkg::LENGTH_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic [7:0]                           rx_char,
    input  logic [rmbp_pkg::MAX_ARG_W-1:0]       max_arg_count,
    input  logic [rmbp_pkg::MAX_BULK_W-1:0]      max_bulk_length,
    input  rmbp_pkg::num_st_t                    num_st,
    output rmbp_pkg::num_ctl_t                   num_ctl,
    input  logic                                 ev_stall,
    output logic                                 ev_valid,
    output logic [1:0]                           event_res,
    output logic [7:0]                           data,
    output logic [rmbp_pkg::ARG_INDEX_W-1:0]     arg_index,
    output logic [1:0]                           error_code
);
    import rmbp_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR, PH_CNT0, PH_CNT1, PH_CNT2, PH_CNTLF, PH_DOLLAR,
        PH_LEN0, PH_LEN1, PH_LEN2, PH_LENLF, PH_PAY, PH_TR1, PH_TR2
    } phase_t;

    localparam logic [32:0] CNT_MASK = (33'd1 << COUNT_BITS) - 33'd1;
    localparam logic [32:0] LEN_MASK = (33'd1 << LENGTH_BITS) - 33'd1;

    function automatic phase_t cnt_phase(input logic [1:0] s);
        phase_t p;
        case (s)
            SUB_SIGN:   p = PH_CNT1;
            SUB_DIGITS: p = PH_CNT2;
            default:    p = PH_CNT0;
        endcase
        return p;
    endfunction

    function automatic phase_t len_phase(input logic [1:0] s);
        phase_t p;
        case (s)
            SUB_SIGN:   p = PH_LEN1;
            SUB_DIGITS: p = PH_LEN2;
            default:    p = PH_LEN0;
        endcase
        return p;
    endfunction

    phase_t                   phase_reg, phase_next;
    logic [COUNT_BITS-1:0]    expected_reg, expected_next;
    logic [COUNT_BITS-1:0]    done_reg, done_next;
    logic [LENGTH_BITS-1:0]   left_reg, left_next;
    logic                     halted_reg, halted_next;
    logic                     ev_valid_reg, ev_valid_next;
    logic [1:0]               event_reg;
    logic [7:0]               data_reg;
    logic [ARG_INDEX_W-1:0]   index_reg;
    logic [1:0]               error_reg;

    logic                     res_vld;
    logic [1:0]               res_ev;
    logic [7:0]               res_data;
    logic [1:0]               res_err;
    logic [1:0]               sub;
    logic                     num_ok;
    logic [32:0]              acc_ext;
    logic                     cnt_bad;
    logic                     len_bad;
    logic [COUNT_BITS:0]      done_p1;
    logic                     last_arg;
    logic [LENGTH_BITS-1:0]   left_dec;
    logic [31:0]              done_ext;

    always_comb
    begin
        case (phase_reg)
            PH_CNT1, PH_LEN1: sub = SUB_SIGN;
            PH_CNT2, PH_LEN2: sub = SUB_DIGITS;
            default:          sub = SUB_NONE;
        endcase
    end

    assign num_ok   = !num_st.invalid && (sub == SUB_DIGITS);
    assign acc_ext  = 33'(num_st.accum);
    assign cnt_bad  = (acc_ext > 33'(max_arg_count)) || (acc_ext > CNT_MASK);
    assign len_bad  = !num_ok || num_st.negative
                    || (acc_ext > 33'(max_bulk_length)) || (acc_ext > LEN_MASK);
    assign done_p1  = (COUNT_BITS+1)'(done_reg) + (COUNT_BITS+1)'(1);
    assign last_arg = done_p1 >= (COUNT_BITS+1)'(expected_reg);
    assign left_dec = left_reg - LENGTH_BITS'(1);
    assign done_ext = 32'(done_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        done_next     = done_reg;
        left_next     = left_reg;
        halted_next   = halted_reg;
        res_vld       = 1'b0;
        res_ev        = EV_PAYLOAD;
        res_data      = 8'd0;
        res_err       = ERR_NONE;
        num_ctl.clr     = 1'b0;
        num_ctl.feed    = 1'b0;
        num_ctl.sub     = sub;
        num_ctl.rx_char = rx_char;

        if (advance && !halted_reg)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    num_ctl.clr = 1'b1;
                    phase_next  = PH_CNT0;
                end
                PH_CNT0, PH_CNT1, PH_CNT2:
                begin
                    if (rx_char != CH_CR)
                    begin
                        num_ctl.feed = 1'b1;
                        phase_next   = cnt_phase(num_st.sub_next);
                    end
                    else if (!num_ok)
                    begin
                        res_vld     = 1'b1;
                        res_ev      = EV_ERROR;
                        res_err     = ERR_BAD_COUNT;
                        halted_next = 1'b1;
                    end
                    else if (num_st.negative || (num_st.accum == '0))
                    begin
                        // empty command, skipped
                        expected_next = '0;
                        done_next     = '0;
                        phase_next    = PH_CNTLF;
                    end
                    else if (cnt_bad)
                    begin
                        res_vld     = 1'b1;
                        res_ev      = EV_ERROR;
                        res_err     = ERR_BAD_COUNT;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        expected_next = COUNT_BITS'(num_st.accum);
                        done_next     = '0;
                        phase_next    = PH_CNTLF;
                    end
                end
                PH_CNTLF:
                begin
                    phase_next = (expected_reg == '0) ? PH_HDR : PH_DOLLAR;
                end
                PH_DOLLAR:
                begin
                    if (rx_char != CH_DOLLAR)
                    begin
                        res_vld     = 1'b1;
                        res_ev      = EV_ERROR;
                        res_err     = ERR_NO_DOLLAR;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        num_ctl.clr = 1'b1;
                        phase_next  = PH_LEN0;
                    end
                end
                PH_LEN0, PH_LEN1, PH_LEN2:
                begin
                    if (rx_char != CH_CR)
                    begin
                        num_ctl.feed = 1'b1;
                        phase_next   = len_phase(num_st.sub_next);
                    end
                    else if (len_bad)
                    begin
                        res_vld     = 1'b1;
                        res_ev      = EV_ERROR;
                        res_err     = ERR_BAD_LENGTH;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        left_next  = LENGTH_BITS'(num_st.accum);
                        phase_next = PH_LENLF;
                    end
                end
                PH_LENLF:
                begin
                    phase_next = (left_reg == '0) ? PH_TR1 : PH_PAY;
                end
                PH_PAY:
                begin
                    left_next = left_dec;
                    if (left_dec == '0)
                        phase_next = PH_TR1;
                    res_vld  = 1'b1;
                    res_ev   = EV_PAYLOAD;
                    res_data = rx_char;
                end
                PH_TR1:
                begin
                    phase_next = PH_TR2;
                end
                PH_TR2:
                begin
                    res_vld = 1'b1;
                    if (last_arg)
                    begin
                        res_ev        = EV_CMD_END;
                        done_next     = '0;
                        expected_next = '0;
                        phase_next    = PH_HDR;
                    end
                    else
                    begin
                        res_ev     = EV_ARG_END;
                        done_next  = done_p1[COUNT_BITS-1:0];
                        phase_next = PH_DOLLAR;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR;
                end
            endcase
        end
    end

    // result register frees when taken; refilled by each processed byte that yields an event
    assign ev_valid_next = advance ? res_vld : (ev_valid_reg && ev_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR;
            expected_reg <= '0;
            done_reg     <= '0;
            left_reg     <= '0;
            halted_reg   <= 1'b0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            done_reg     <= done_next;
            left_reg     <= left_next;
            halted_reg   <= halted_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_vld)
        begin
            event_reg <= res_ev;
            data_reg  <= res_data;
            index_reg <= (res_err == ERR_BAD_COUNT) ? '0 : done_ext[ARG_INDEX_W-1:0];
            error_reg <= res_err;
        end
    end

    assign ev_valid   = ev_valid_reg;
    assign event_res  = event_reg;
    assign data       = data_reg;
    assign arg_index  = index_reg;
    assign error_code = error_reg;

endmodule

FILE: rtl/core/rmbp_check.sv
// Port-level checker for the multibulk request parser, bound to the top level.
`include "assert_macros.svh"

module rmbp_check (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_stall,
    input logic       ev_valid,
    input logic       ev_stall,
    input logic [1:0] event_res,
    input logic [7:0] data,
    input logic [1:0] error_code
);
    import rmbp_pkg::*;

    logic ev_is_err;
    logic ev_is_payload;
    logic ev_taken_err;
    logic has_err;

    assign ev_is_err     = (event_res == EV_ERROR);
    assign ev_is_payload = (event_res == EV_PAYLOAD);
    assign ev_taken_err  = ev_valid && !ev_stall && ev_is_err;
    assign has_err       = (error_code != ERR_NONE);

    // no event may follow a delivered protocol error
    `ASSERT_CLK(a_silent_after_error, ev_taken_err |=> !ev_valid, "event after protocol error")

    // input backpressure only comes from a stalled, full result register
    `ASSERT_CLK(a_stall_cause, rx_stall |-> (ev_valid && ev_stall), "stall without cause")

    // error code is set exactly on error events; data only on payload events
    `ASSERT_CLK(a_err_code, ev_valid |-> (ev_is_err == has_err), "error_code mismatch")

    `ASSERT_CLK(a_data_zero, (ev_valid && !ev_is_payload) |-> (data == 8'd0), "stray data")

    `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !ev_valid, "ev_valid during reset")

endmodule

bind resp_multibulk_request_parser rmbp_check u_rmbp_check (.*);

FILE: tb/resp_multibulk_request_parser_test.sv
// Testbench for the multibulk request parser: directed and random byte streams checked against a predictor.
module resp_multibulk_request_parser_test;
    import rmbp_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 6;
    localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS_DEF) - 1;
    localparam logic [63:0] LENGTH_MAX = (64'd1 << LENGTH_BITS_DEF) - 1;
    localparam logic [7:0] STAR = 8'h2A;
    localparam logic [7:0] LINE_FEED = 8'h0A;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_COUNT,
        PH_COUNT_LF,
        PH_DOLLAR,
        PH_LENGTH,
        PH_LENGTH_LF,
        PH_PAYLOAD,
        PH_TRAILER1,
        PH_TRAILER2
    } parse_phase_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [7:0]             value;
        logic [ARG_INDEX_W-1:0] arg_idx;
        logic [1:0]             err;
    } parse_event_t;

    typedef logic [7:0] byte_q_t[$];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic rx_valid = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic ev_stall = 1'b0;
    logic rx_stall;
    logic ev_valid;
    logic [1:0] event_res;
    logic [7:0] data;
    logic [ARG_INDEX_W-1:0] arg_index;
    logic [1:0] error_code;

    // parser state as predicted
    parse_phase_t prs_phase = PH_HEADER;
    logic [ACC_W-1:0] num_acc = '0;
    logic num_neg = 1'b0;
    logic num_bad = 1'b0;
    logic [1:0] num_sub = SUB_NONE;
    int unsigned args_expected = 0;
    int unsigned args_done = 0;
    int unsigned payload_left = 0;
    bit halted = 1'b0;
    int unsigned arg_limit = 32'(MAX_ARG_RESET);
    int unsigned bulk_limit = 32'(MAX_BULK_RESET);

    parse_event_t pending_events[$];
    int unsigned error_count = 0;
    int unsigned bytes_sent = 0;
    bit rx_gaps_on = 1'b1;
    bit ev_stalls_on = 1'b1;
    int hold_cycles = 0;

    resp_multibulk_request_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .ev_valid   (ev_valid),
        .ev_stall   (ev_stall),
        .event_res  (event_res),
        .data       (data),
        .arg_index  (arg_index),
        .error_code (error_code)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void clear_number();
        num_acc = '0;
        num_neg = 1'b0;
        num_bad = 1'b0;
        num_sub = SUB_NONE;
    endfunction

    function automatic void feed_digit(input logic [7:0] b);
        logic [7:0] d;
        logic [63:0] v;
        d = b - CH_DIGIT_0;
        if (b == CH_MINUS && num_sub == SUB_NONE) begin
            num_neg = 1'b1;
            num_sub = SUB_SIGN;
        end else if (b < CH_DIGIT_0 || b > CH_DIGIT_9) begin
            num_bad = 1'b1;
        end else if (num_sub == SUB_DIGITS) begin
            // a leading zero cannot take more digits
            if (num_acc == 0) begin
                num_bad = 1'b1;
            end else begin
                v = 64'(num_acc) * 64'd10 + 64'(d);
                if (v > 64'(ACC_CAP)) begin
                    v = 64'(ACC_CAP);
                    num_bad = 1'b1;
                end
                num_acc = v[ACC_W-1:0];
            end
        end else begin
            if (num_sub == SUB_SIGN && d == 0)
                num_bad = 1'b1;
            num_acc = ACC_W'(d);
            num_sub = SUB_DIGITS;
        end
    endfunction

    function automatic bit number_ok();
        return !num_bad && num_sub == SUB_DIGITS;
    endfunction

    function automatic parse_event_t make_event(input logic [1:0] kind, input logic [7:0] value,
                                                input logic [1:0] err);
        parse_event_t e;
        e.kind = kind;
        e.value = value;
        e.err = err;
        e.arg_idx = (kind == EV_ERROR && err == ERR_BAD_COUNT) ? '0 : args_done[ARG_INDEX_W-1:0];
        return e;
    endfunction

    function automatic parse_event_t error_event(input logic [1:0] err);
        halted = 1'b1;
        return make_event(EV_ERROR, 8'h00, err);
    endfunction

    // Advances the predicted parser by one byte; returns 1 when the byte yields an event.
    function automatic bit parse_byte(input logic [7:0] b, output parse_event_t e);
        bit hit;
        hit = 1'b0;
        e = '0;
        if (!halted) begin
            case (prs_phase)
                PH_HEADER: begin
                    clear_number();
                    prs_phase = PH_COUNT;
                end
                PH_COUNT: begin
                    if (b != CH_CR) begin
                        feed_digit(b);
                    end else if (!number_ok() ||
                                 (!num_neg && (num_acc > arg_limit || num_acc > COUNT_MAX))) begin
                        e = error_event(ERR_BAD_COUNT);
                        hit = 1'b1;
                    end else begin
                        args_expected = (num_neg || num_acc == 0) ? 0 : 32'(num_acc);
                        args_done = 0;
                        prs_phase = PH_COUNT_LF;
                    end
                end
                PH_COUNT_LF: prs_phase = (args_expected == 0) ? PH_HEADER : PH_DOLLAR;
                PH_DOLLAR: begin
                    if (b != CH_DOLLAR) begin
                        e = error_event(ERR_NO_DOLLAR);
                        hit = 1'b1;
                    end else begin
                        clear_number();
                        prs_phase = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    if (b != CH_CR) begin
                        feed_digit(b);
                    end else if (!number_ok() || num_neg || num_acc > bulk_limit ||
                                 num_acc > LENGTH_MAX) begin
                        e = error_event(ERR_BAD_LENGTH);
                        hit = 1'b1;
                    end else begin
                        payload_left = 32'(num_acc);
                        prs_phase = PH_LENGTH_LF;
                    end
                end
                PH_LENGTH_LF: prs_phase = (payload_left == 0) ? PH_TRAILER1 : PH_PAYLOAD;
                PH_PAYLOAD: begin
                    payload_left--;
                    if (payload_left == 0)
                        prs_phase = PH_TRAILER1;
                    e = make_event(EV_PAYLOAD, b, ERR_NONE);
                    hit = 1'b1;
                end
                PH_TRAILER1: prs_phase = PH_TRAILER2;
                PH_TRAILER2: begin
                    hit = 1'b1;
                    if (args_done + 1 >= args_expected) begin
                        e = make_event(EV_CMD_END, 8'h00, ERR_NONE);
                        args_done = 0;
                        args_expected = 0;
                        prs_phase = PH_HEADER;
                    end else begin
                        e = make_event(EV_ARG_END, 8'h00, ERR_NONE);
                        args_done = 32'((64'(args_done) + 1) & COUNT_MAX);
                        prs_phase = PH_DOLLAR;
                    end
                end
                default: prs_phase = PH_HEADER;
            endcase
        end
        return hit;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    function automatic logic [7:0] filler(input logic [7:0] usual);
        return ($urandom_range(0, 3) != 0) ? usual : 8'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned pick_length();
        int unsigned top;
        top = (bulk_limit < 40) ? bulk_limit : 40;
        case ($urandom_range(0, 9))
            0: return top;
            1, 2, 3: return $urandom_range(0, top);
            default: return $urandom_range(0, (top < 6) ? top : 6);
        endcase
    endfunction

    always @(posedge clk) begin : event_checker
        parse_event_t want;
        if (rst_n && ev_valid && !ev_stall) begin
            if (pending_events.size() == 0) begin
                $error("event with none expected: event_res %0d data 0x%0h error_code %0d",
                       event_res, data, error_code);
                error_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_res", 32'(want.kind), 32'(event_res));
                check_field("data", 32'(want.value), 32'(data));
                check_field("arg_index", 32'(want.arg_idx), 32'(arg_index));
                check_field("error_code", 32'(want.err), 32'(error_code));
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                ev_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                ev_stall <= 1'b0;
            end else if (ev_stalls_on && $urandom_range(0, 5) == 0) begin
                ev_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                ev_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        parse_event_t e;
        if (rx_gaps_on && $urandom_range(0, 7) == 0) begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        bytes_sent++;
        if (parse_byte(b, e))
            pending_events = {pending_events, e};
    endtask

    // Lowers valid in the step of the last transaction, then waits out every event.
    task automatic wait_idle();
        rx_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MAX_ARG_COUNT)
            arg_limit = 32'(val[MAX_ARG_W-1:0]);
        else
            bulk_limit = 32'(val[MAX_BULK_W-1:0]);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_byte(CH_CR);
        send_byte(filler(LINE_FEED));
    endtask

    task automatic send_header();
        send_byte(filler(STAR));
    endtask

    task automatic send_bulk(input byte_q_t payload);
        send_byte(CH_DOLLAR);
        send_line($sformatf("%0d", payload.size()));
        foreach (payload[i])
            send_byte(payload[i]);
        send_byte(filler(CH_CR));
        send_byte(filler(LINE_FEED));
    endtask

    task automatic send_random_bulk(input int unsigned len);
        byte_q_t payload;
        repeat (len) payload = {payload, 8'($urandom_range(0, 255))};
        send_bulk(payload);
    endtask

    task automatic send_random_command();
        int unsigned cap;
        int unsigned n;
        cap = (arg_limit < 6) ? arg_limit : 6;
        send_header();
        if (cap == 0 || $urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 2) == 0)
                send_line("0");
            else
                send_line($sformatf("-%0d", $urandom_range(1, 32'h7FFF_FFFF)));
        end else begin
            n = $urandom_range(1, cap);
            send_line($sformatf("%0d", n));
            repeat (n) send_random_bulk(pick_length());
        end
    endtask

    task automatic test_basic_framing();
        byte_q_t q;
        send_byte(8'hFF);
        send_text("2");
        send_byte(CH_CR);
        send_byte(8'h00);
        q = {8'h00, 8'hFF, CH_CR};
        send_bulk(q);
        q = {CH_DOLLAR, 8'h7F, 8'h80};
        send_bulk(q);
        send_byte(8'h00);
        send_line("1");
        q = {8'h55, 8'hAA};
        send_bulk(q);
    endtask

    // counts of zero or less skip the command
    task automatic test_skipped_commands();
        send_header();
        send_line("0");
        send_byte(CH_DOLLAR);
        send_line("-1");
        send_header();
        send_line("-2147483647");
        send_header();
        send_line("1");
        send_random_bulk(3);
    endtask

    task automatic test_empty_arguments();
        send_header();
        send_line("3");
        send_random_bulk(0);
        send_random_bulk(0);
        send_random_bulk(2);
    endtask

    task automatic test_register_extremes();
        write_reg(REG_MAX_ARG_COUNT, '0);
        send_header();
        send_line("0");
        send_header();
        send_line("-7");
        write_reg(REG_MAX_ARG_COUNT, CFG_DATA_W'(3));
        write_reg(REG_MAX_BULK_LENGTH, '0);
        send_header();
        send_line("3");
        repeat (3) send_random_bulk(0);
        write_reg(REG_MAX_BULK_LENGTH, CFG_DATA_W'(4));
        send_header();
        send_line("1");
        send_random_bulk(4);
        write_reg(REG_MAX_ARG_COUNT, CFG_DATA_W'(MAX_ARG_RESET));
        write_reg(REG_MAX_BULK_LENGTH, CFG_DATA_W'(MAX_BULK_RESET));
        send_header();
        send_line("2");
        send_random_bulk(5);
        send_random_bulk(1);
    endtask

    // Receiver holds off while the sender keeps offering bytes, then the sender drains.
    task automatic test_backpressure();
        rx_gaps_on = 1'b0;
        ev_stalls_on = 1'b0;
        hold_cycles = 80;
        send_header();
        send_line("2");
        send_random_bulk(48);
        send_random_bulk(6);
        wait_idle();
        rx_gaps_on = 1'b1;
        ev_stalls_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned goal;
        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(0, 4))
                0: write_reg(REG_MAX_ARG_COUNT, '0);
                1: write_reg(REG_MAX_ARG_COUNT, CFG_DATA_W'(1));
                2: write_reg(REG_MAX_ARG_COUNT, CFG_DATA_W'($urandom_range(2, 6)));
                3: write_reg(REG_MAX_ARG_COUNT, CFG_DATA_W'($urandom_range(7, 100)));
                default: write_reg(REG_MAX_ARG_COUNT, CFG_DATA_W'(MAX_ARG_RESET));
            endcase
            case ($urandom_range(0, 4))
                0: write_reg(REG_MAX_BULK_LENGTH, '0);
                1: write_reg(REG_MAX_BULK_LENGTH, CFG_DATA_W'(1));
                2: write_reg(REG_MAX_BULK_LENGTH, CFG_DATA_W'($urandom_range(2, 40)));
                3: write_reg(REG_MAX_BULK_LENGTH, CFG_DATA_W'($urandom_range(41, 1000)));
                default: write_reg(REG_MAX_BULK_LENGTH, CFG_DATA_W'(MAX_BULK_RESET));
            endcase
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            ev_stalls_on = ($urandom_range(0, 3) != 0);
            goal = bytes_sent + 70;
            while (bytes_sent < goal)
                send_random_command();
        end
    endtask

    task automatic test_steady_stream();
        rx_gaps_on = 1'b0;
        ev_stalls_on = 1'b0;
        write_reg(REG_MAX_ARG_COUNT, CFG_DATA_W'(MAX_ARG_RESET));
        write_reg(REG_MAX_BULK_LENGTH, CFG_DATA_W'(MAX_BULK_RESET));
        repeat (3) send_random_command();
    endtask

    // One protocol error of a random kind, then bytes that must all be dropped.
    task automatic test_protocol_error();
        string bad_counts[12] = '{"", "-", "-0", "007", "+5", "1a", "12-", "00",
                                  "2147483648", "99999999999", "-2147483648", "2097152"};
        string bad_lengths[10] = '{"", "-", "-5", "-0", "00", "+3", "9x",
                                   "2147483648", "1073741824", "-99999999999"};
        logic [7:0] stray;
        send_header();
        case ($urandom_range(0, 4))
            0: send_line(bad_counts[$urandom_range(0, 11)]);
            1: send_line($sformatf("%0d", arg_limit + 1 + $urandom_range(0, 9)));
            2: begin
                send_line("3");
                send_random_bulk(pick_length());
                do
                    stray = 8'($urandom_range(0, 255));
                while (stray == CH_DOLLAR);
                send_byte(stray);
            end
            3: begin
                send_line("2");
                send_byte(CH_DOLLAR);
                send_line(bad_lengths[$urandom_range(0, 9)]);
            end
            default: begin
                send_line("2");
                send_random_bulk(pick_length());
                send_byte(CH_DOLLAR);
                send_line($sformatf("%0d", bulk_limit + 1 + $urandom_range(0, 9)));
            end
        endcase
        repeat (24) send_byte(8'($urandom_range(0, 255)));
        send_header();
        send_line("1");
        send_random_bulk(4);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_framing();
        test_skipped_commands();
        test_empty_arguments();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        test_steady_stream();
        test_protocol_error();
        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rmbp_pkg.sv
rtl/core/rmbp_num.sv
rtl/core/rmbp_fsm.sv
rtl/core/resp_multibulk_request_parser.sv
rtl/core/rmbp_check.sv
tb/resp_multibulk_request_parser_test.sv
